/* rtl/moving_sum_bandpass_filter_unit_defines.svh */
// Assertion macros shared by the checker of the moving-sum band-pass filter.
`ifndef MOVING_SUM_BANDPASS_FILTER_UNIT_DEFINES_SVH
`define MOVING_SUM_BANDPASS_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("msbf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("msbf check failed");

`endif

/* rtl/msbf_pkg.sv */
// Shared constants and types of the moving-sum band-pass filter.
`default_nettype none
package msbf_pkg;
	localparam int SAMPLE_W          = 16;
	localparam int GAIN_W            = 10;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd384;
	localparam int LP_SHIFT          = 10;
	localparam int HP_SHIFT          = 7;
	localparam int LOWPASS_TAPS_DEF  = 4;
	localparam int HIGHPASS_TAPS_DEF = 128;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	// Register index codes, taken from paddr[2].
	localparam logic REG_IDX_GAIN = 1'b0;

	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

	// Per-cycle control of the low-pass ring memory.
	typedef struct packed {
		logic adv;   // whole pipeline moves one stage
		logic rd;    // a new word enters, read its oldest entry
		logic wr;    // the word in stage two writes its low-pass value
	} ring_ctl_t;
endpackage
`default_nettype wire

/* rtl/msbf_sample_window.sv */
// Short delay line of raw samples with its running window sum.
`default_nettype none
module msbf_sample_window #(
	parameter int LOWPASS_TAPS = msbf_pkg::LOWPASS_TAPS_DEF,
	parameter int SUM_W        = msbf_pkg::SAMPLE_W + $clog2(LOWPASS_TAPS)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic signed [msbf_pkg::SAMPLE_W-1:0] sample,
	output logic signed [SUM_W-1:0]                  window_sum
);
	logic signed [msbf_pkg::SAMPLE_W-1:0] taps_q [LOWPASS_TAPS];
	logic signed [SUM_W-1:0]              sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOWPASS_TAPS; i++) taps_q[i] <= '0;
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_q + SUM_W'(sample) - SUM_W'(taps_q[LOWPASS_TAPS-1]);
			taps_q[0] <= sample;
			for (int i = 1; i < LOWPASS_TAPS; i++) taps_q[i] <= taps_q[i-1];
		end
	end

	assign window_sum = sum_q;
endmodule
`default_nettype wire

/* rtl/msbf_lp_ring.sv */
// Ring memory of recent low-pass values with fill tracking and write forwarding.
`default_nettype none
module msbf_lp_ring #(
	parameter int HIGHPASS_TAPS = msbf_pkg::HIGHPASS_TAPS_DEF,
	parameter int DATA_W        = 18
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire msbf_pkg::ring_ctl_t      ctl,
	input  wire logic signed [DATA_W-1:0] wr_data,
	output logic signed [DATA_W-1:0]      oldest
);
	localparam int AW = $clog2(HIGHPASS_TAPS);
	localparam logic [AW-1:0] LastPos = AW'(HIGHPASS_TAPS - 1);

	logic signed [DATA_W-1:0] mem [HIGHPASS_TAPS];
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] fwd_data_s1;
	logic [AW-1:0]            pos_q;
	logic [AW-1:0]            addr_s1;
	logic [AW-1:0]            addr_s2;
	logic                     filled_q;
	logic                     live_s1;
	logic                     fwd_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr) mem[addr_s2] <= wr_data;
		if (ctl.rd) rdata_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			live_s1  <= 1'b0;
			fwd_s1   <= 1'b0;
			addr_s1  <= '0;
			addr_s2  <= '0;
		end else begin
			if (ctl.rd) begin
				pos_q   <= (pos_q == LastPos) ? '0 : pos_q + 1'b1;
				addr_s1 <= pos_q;
				live_s1 <= filled_q;
				fwd_s1  <= ctl.wr && (addr_s2 == pos_q);
				if (pos_q == LastPos) filled_q <= 1'b1;
			end
			if (ctl.adv) addr_s2 <= addr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) fwd_data_s1 <= wr_data;
	end

	// Entries of the first lap were never written and read as zero.
	always_comb begin
		if (fwd_s1)       oldest = fwd_data_s1;
		else if (live_s1) oldest = rdata_q;
		else              oldest = '0;
	end
endmodule
`default_nettype wire

/* rtl/moving_sum_bandpass_filter_unit.sv */
// Top level of the moving-sum band-pass filter with its stream and register ports.
`default_nettype none
// The filter takes one signed 16-bit sample per input word and returns one
// saturated signed 16-bit band-passed sample per output word, in order. It
// accepts a word in every clock cycle; a result reaches the master side in the
// output register after the window sum, product and stage-three registers. When that
// register holds a word the sink does not take, the whole pipeline stalls and
// s_axis_tready drops in the same cycle; a word is taken while the held result
// leaves. The low-pass value is the sum of the last LOWPASS_TAPS samples times
// lowpass_gain, shifted right by ten with floor; the high-pass result is that
// value minus the sum of the last HIGHPASS_TAPS low-pass values shifted right
// by seven, clamped to -32768..32767. The low-pass history lives in a
// synchronous RAM of HIGHPASS_TAPS entries that is read when a word enters and
// written when that word is in stage two; a fill flag makes entries of the first lap
// read as zero, so no clearing pass is needed after reset. lowpass_gain sits at
// byte address 0 of the APB port, resets to 384 and must only be written while
// the filter is idle.
module moving_sum_bandpass_filter_unit #(
	parameter int LOWPASS_TAPS  = msbf_pkg::LOWPASS_TAPS_DEF,
	parameter int HIGHPASS_TAPS = msbf_pkg::HIGHPASS_TAPS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream.
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [15:0]                       s_axis_tdata,  // [15:0] sample
	// Output stream.
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [15:0]                            m_axis_tdata,  // [15:0] filtered
	// Register port.
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [msbf_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [msbf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [msbf_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready
);
	// Window sum, low-pass value, product, high-pass accumulator and difference widths.
	localparam int SW  = msbf_pkg::SAMPLE_W + $clog2(LOWPASS_TAPS);
	localparam int LPW = SW;
	localparam int PW  = SW + msbf_pkg::GAIN_W + 1;
	localparam int LSW = LPW + $clog2(HIGHPASS_TAPS);
	localparam int HW  = LSW + 1;

	localparam logic signed [HW-1:0] HpMax = HW'(msbf_pkg::OUT_MAX);
	localparam logic signed [HW-1:0] HpMin = HW'(msbf_pkg::OUT_MIN);

	// Register port: only the gain register exists.
	logic [msbf_pkg::GAIN_W-1:0] gain_q;
	logic                        gain_wr;

	assign pready  = 1'b1;
	assign gain_wr = psel && penable && pwrite && pready && (paddr[2] == msbf_pkg::REG_IDX_GAIN);
	assign prdata  = (paddr[2] == msbf_pkg::REG_IDX_GAIN)
		? msbf_pkg::APB_DATA_W'(gain_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= msbf_pkg::GAIN_RESET;
		end else if (gain_wr) begin
			gain_q <= pwdata[msbf_pkg::GAIN_W-1:0];
		end
	end

	// The pipeline moves as one unless the output register is held.
	logic adv;
	logic accept;
	logic out_valid_q;
	logic signed [15:0] out_data_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	// Stage zero: raw-sample window; its sum register serves as stage one.
	logic signed [SW-1:0] win_sum;

	msbf_sample_window #(
		.LOWPASS_TAPS(LOWPASS_TAPS),
		.SUM_W       (SW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.sample    ($signed(s_axis_tdata)),
		.window_sum(win_sum)
	);

	// Pipeline valids.
	logic valid_s1, valid_s2, valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Ring memory of low-pass values.
	msbf_pkg::ring_ctl_t   ring_ctl;
	logic signed [LPW-1:0] lp;
	logic signed [LPW-1:0] oldest;

	assign ring_ctl.adv = adv;
	assign ring_ctl.rd  = accept;
	assign ring_ctl.wr  = adv && valid_s2;

	msbf_lp_ring #(
		.HIGHPASS_TAPS(HIGHPASS_TAPS),
		.DATA_W       (LPW)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.wr_data(lp),
		.oldest (oldest)
	);

	// Stage one to two: gain multiply; the oldest ring entry travels along.
	logic signed [PW-1:0]  prod_s2;
	logic signed [LPW-1:0] oldest_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2   <= PW'(win_sum) * PW'($signed({1'b0, gain_q}));
			oldest_s2 <= oldest;
		end
	end

	// Stage two: floor shift by ten, update the high-pass running sum.
	logic signed [LSW-1:0] lsum_q;
	logic signed [LSW-1:0] lsum_next;

	assign lp        = $signed(prod_s2[msbf_pkg::LP_SHIFT+LPW-1:msbf_pkg::LP_SHIFT]);
	assign lsum_next = lsum_q + LSW'(lp) - LSW'(oldest_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
		end else if (adv && valid_s2) begin
			lsum_q <= lsum_next;
		end
	end

	logic signed [LPW-1:0] lp_s3;
	logic signed [LSW-1:0] lsum_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			lp_s3   <= lp;
			lsum_s3 <= lsum_next;
		end
	end

	// Stage three: subtract the floored average and clamp.
	logic signed [HW-1:0] hp;
	logic signed [15:0]   hp_sat;

	assign hp = HW'(lp_s3) - HW'(lsum_s3 >>> msbf_pkg::HP_SHIFT);

	always_comb begin
		if (hp > HpMax)      hp_sat = msbf_pkg::OUT_MAX;
		else if (hp < HpMin) hp_sat = msbf_pkg::OUT_MIN;
		else                 hp_sat = hp[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) out_data_q <= hp_sat;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire

/* rtl/msbf_checker.sv */
// Port-level checker of the moving-sum band-pass filter and its bind.
`default_nettype none
`include "moving_sum_bandpass_filter_unit_defines.svh"
module msbf_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [15:0]                     m_axis_tdata,
	input wire logic                            psel,
	input wire logic                            penable,
	input wire logic                            pwrite,
	input wire logic [msbf_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [msbf_pkg::APB_DATA_W-1:0] pwdata,
	input wire logic [msbf_pkg::APB_DATA_W-1:0] prdata,
	input wire logic                            pready
);
	logic                        out_held;
	logic                        gain_sel;
	logic                        gain_write;
	logic [msbf_pkg::GAIN_W-1:0] gain_rdata;
	logic [msbf_pkg::GAIN_W-1:0] gain_wdata;

	assign out_held   = m_axis_tvalid && !m_axis_tready;
	assign gain_sel   = paddr[2] == msbf_pkg::REG_IDX_GAIN;
	assign gain_write = psel && penable && pwrite && pready && gain_sel;
	assign gain_rdata = prdata[msbf_pkg::GAIN_W-1:0];
	assign gain_wdata = pwdata[msbf_pkg::GAIN_W-1:0];

	// A held result keeps its word.
	`MSBF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, m_axis_tvalid && $stable(m_axis_tdata))

	// The input side is open exactly when the output register can move.
	`MSBF_ASSERT_NOW(a_ready_follows_out, clk, arst_n, 1'b1, s_axis_tready == !out_held)

	// A gain write is read back at the gain address in the following cycle.
	`MSBF_ASSERT_NEXT(a_gain_readback, clk, arst_n, gain_write, !gain_sel || gain_rdata == $past(gain_wdata))
endmodule

bind moving_sum_bandpass_filter_unit msbf_checker u_msbf_checker (.*);
`default_nettype wire

/* dv/moving_sum_bandpass_filter_unit_checker.sv */
// Checker of the moving-sum band-pass filter: predicts each filtered word and compares it.
`timescale 1ns / 100ps
module moving_sum_bandpass_filter_unit_checker
	import msbf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [15:0]           s_axis_tdata,  // [15:0] sample
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [15:0]           m_axis_tdata,  // [15:0] filtered
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	input  wire logic [APB_DATA_W-1:0] prdata,
	input  wire logic                  pready,
	output int                         mismatch_total,
	output int                         words_due
);
	localparam int LP_TAPS = LOWPASS_TAPS_DEF;
	localparam int HP_TAPS = HIGHPASS_TAPS_DEF;

	// Predictor state: both delay lines, their running sums and the gain.
	logic signed [SAMPLE_W-1:0] sample_line [LP_TAPS];
	longint                     sample_sum;
	int                         sample_slot;
	longint                     lowpass_line [HP_TAPS];
	longint                     lowpass_sum;
	int                         lowpass_slot;
	logic [GAIN_W-1:0]          gain;

	logic signed [SAMPLE_W-1:0] filtered_due [$];
	int                         mismatches;

	function automatic logic signed [SAMPLE_W-1:0] filter_sample(
		input logic signed [SAMPLE_W-1:0] x
	);
		longint lowpass;
		longint bandpass;
		sample_sum += longint'(x) - longint'(sample_line[sample_slot]);
		sample_line[sample_slot] = x;
		sample_slot = (sample_slot + 1) % LP_TAPS;
		// Arithmetic shifts of signed values round toward minus infinity.
		lowpass = (sample_sum * longint'(gain)) >>> LP_SHIFT;
		lowpass_sum += lowpass - lowpass_line[lowpass_slot];
		lowpass_line[lowpass_slot] = lowpass;
		lowpass_slot = (lowpass_slot + 1) % HP_TAPS;
		bandpass = lowpass - (lowpass_sum >>> HP_SHIFT);
		if (bandpass > longint'(OUT_MAX))
			bandpass = longint'(OUT_MAX);
		if (bandpass < longint'(OUT_MIN))
			bandpass = longint'(OUT_MIN);
		return bandpass[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_W-1:0] due;
		if (!arst_n) begin
			for (int i = 0; i < LP_TAPS; i++)
				sample_line[i] = '0;
			for (int i = 0; i < HP_TAPS; i++)
				lowpass_line[i] = 0;
			sample_sum = 0;
			sample_slot = 0;
			lowpass_sum = 0;
			lowpass_slot = 0;
			gain = GAIN_RESET;
			filtered_due.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pready && paddr[2] == REG_IDX_GAIN) begin
				if (pwrite) begin
					gain = pwdata[GAIN_W-1:0];
				end else if (prdata != APB_DATA_W'(gain)) begin
					$display("%0t: lowpass_gain read expected %0d got %0d",
						$time, gain, prdata);
					mismatches++;
				end
			end
			// Results are taken before new samples so that a word can never match
			// an expectation queued at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (filtered_due.size() == 0) begin
					$display("%0t: filtered expected none got %0d",
						$time, $signed(m_axis_tdata));
					mismatches++;
				end else begin
					due = filtered_due.pop_front();
					if ($signed(m_axis_tdata) != due) begin
						$display("%0t: filtered expected %0d got %0d",
							$time, due, $signed(m_axis_tdata));
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				filtered_due.push_back(filter_sample(s_axis_tdata));
		end
		words_due <= filtered_due.size();
		mismatch_total <= mismatches;
	end
endmodule

/* dv/moving_sum_bandpass_filter_unit_test.sv */
// Top of the testbench of the moving-sum band-pass filter: stimulus, sink and verdict.
`timescale 1ns / 100ps
module moving_sum_bandpass_filter_unit_test;
	import msbf_pkg::*;

	// Address of the gain register, and the one spare slot of the port whose
	// writes the filter must ignore.
	localparam logic [APB_ADDR_W-1:0] GAIN_ADDR  = {REG_IDX_GAIN, 2'b00};
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_IDX_GAIN, 2'b00};
	// The sender's gaps, the sink's stalls and the pipeline are all bounded; a
	// quiet stretch much longer than all of them together is a hang.
	localparam int QUIET_LIMIT   = 500;
	localparam int PHASES        = 7;
	localparam int PHASE_WORDS   = 132;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;   // [15:0] sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;        // [15:0] filtered
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int                    mismatch_total;
	int                    words_due;
	int                    quiet_cycles = 0;
	// When set, neither side idles, so the pipeline runs at full rate.
	bit                    calm = 1'b0;
	// Pending run of repeated samples, used to drive the running sums to their
	// extremes.
	int                    run_left = 0;
	logic [15:0]           run_value = '0;

	always #5 clk = ~clk;

	moving_sum_bandpass_filter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	moving_sum_bandpass_filter_unit_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.mismatch_total (mismatch_total),
		.words_due      (words_due)
	);

	// Offers one sample word after a random gap and returns at the edge where it
	// is taken. With no gap, tvalid simply stays high for the next word.
	task automatic send_sample(input logic [15:0] value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// One APB transfer: a setup cycle, then the access cycle until pready. The
	// trailing idle cycle keeps back-to-back transfers from driving psel twice in
	// one step.
	task automatic reg_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected word has come back. The checker publishes its
	// count through a register, hence the edge before the first look.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random samples: runs of a full-scale value to saturate both stages, runs
	// of an arbitrary value to settle the low-pass, single extremes, small
	// values around zero for the rounding of negative sums, and plain noise.
	function automatic logic [15:0] draw_sample();
		int pick;
		if (run_left > 0) begin
			run_left--;
			return run_value;
		end
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			run_value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			run_left = $urandom_range(4, 40);
			return run_value;
		end
		if (pick < 14) begin
			run_value = 16'($urandom);
			run_left = $urandom_range(2, 20);
			return run_value;
		end
		if (pick < 30)
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		if (pick < 45)
			return 16'(int'($urandom_range(0, 16)) - 8);
		return 16'($urandom);
	endfunction

	// Result sink: stalls a random number of cycles before each word, except in
	// calm phases where tready stays high throughout.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Watchdog: any accepted word or register transfer counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("moving_sum_bandpass_filter_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [15:0]       opening [24];
		logic [GAIN_W-1:0] phase_gain [PHASES];
		opening = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'hFFFD, 16'h0002,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
			16'h0000, 16'h0000};
		// The extremes of the gain, the smallest nonzero one, 512, the reset value
		// written back, and two random settings.
		phase_gain = '{10'd1023, 10'd0, 10'd1, 10'd512, GAIN_W'($urandom_range(2, 1022)),
			GAIN_RESET, GAIN_W'($urandom_range(2, 1022))};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The gain must read back as its reset value before any write.
		reg_access(1'b0, GAIN_ADDR, '0);

		// Directed words at the reset gain: the zeros left in both delay lines
		// after reset, rounding of small negative sums, and full-scale runs of
		// both signs that drive the result into saturation.
		foreach (opening[i])
			send_sample(opening[i]);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			// Random upper bits check that only the low ten bits of the gain are
			// kept; one phase also writes the spare address, which must change
			// nothing.
			reg_access(1'b1, GAIN_ADDR,
				{(APB_DATA_W-GAIN_W)'($urandom), phase_gain[phase]});
			if (phase == 3)
				reg_access(1'b1, SPARE_ADDR, APB_DATA_W'($urandom));
			reg_access(1'b0, GAIN_ADDR, '0);
			calm = (phase % 3 == 2);
			run_left = 0;
			for (int n = 0; n < PHASE_WORDS; n++)
				send_sample(draw_sample());
			drain();
		end

		if (mismatch_total == 0)
			$display("moving_sum_bandpass_filter_unit: match");
		else
			$display("moving_sum_bandpass_filter_unit: mismatch");
		$finish;
	end
endmodule

/* moving_sum_bandpass_filter_unit.f */
+incdir+rtl
rtl/msbf_pkg.sv
rtl/msbf_sample_window.sv
rtl/msbf_lp_ring.sv
rtl/moving_sum_bandpass_filter_unit.sv
rtl/msbf_checker.sv
dv/moving_sum_bandpass_filter_unit_checker.sv
dv/moving_sum_bandpass_filter_unit_test.sv
